// ===== design/tpqg_pkg.sv =====
// Shared types, constants and entry tables for the triangle plane quadric generator.
package tpqg_pkg;

  localparam int COORD_IN_W = 16;
  localparam int SHIFT_W    = 6;
  localparam int VALUE_W    = 64;

  localparam logic [VALUE_W-1:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] SAT_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [3:0] {
    ENTRY_AA,
    ENTRY_AB,
    ENTRY_AC,
    ENTRY_AD,
    ENTRY_BB,
    ENTRY_BC,
    ENTRY_BD,
    ENTRY_CC,
    ENTRY_CD,
    ENTRY_DD
  } entry_e;

  typedef enum logic [1:0] {
    COEF_A,
    COEF_B,
    COEF_C,
    COEF_D
  } coef_e;

  typedef struct packed {
    logic signed [COORD_IN_W-1:0] first_x;
    logic signed [COORD_IN_W-1:0] first_y;
    logic signed [COORD_IN_W-1:0] first_z;
    logic signed [COORD_IN_W-1:0] second_x;
    logic signed [COORD_IN_W-1:0] second_y;
    logic signed [COORD_IN_W-1:0] second_z;
    logic signed [COORD_IN_W-1:0] third_x;
    logic signed [COORD_IN_W-1:0] third_y;
    logic signed [COORD_IN_W-1:0] third_z;
  } tri_in_t;

  typedef struct packed {
    logic [3:0]                entry_index;
    logic signed [VALUE_W-1:0] entry_value;
    logic                      saturated;
    logic                      last_entry;
  } entry_t;

  function automatic coef_e entry_row(input logic [3:0] idx);
    coef_e r;
    case (idx)
      ENTRY_AA, ENTRY_AB, ENTRY_AC, ENTRY_AD: r = COEF_A;
      ENTRY_BB, ENTRY_BC, ENTRY_BD:           r = COEF_B;
      ENTRY_CC, ENTRY_CD:                     r = COEF_C;
      ENTRY_DD:                               r = COEF_D;
      default:                                r = COEF_A;
    endcase
    return r;
  endfunction

  function automatic coef_e entry_col(input logic [3:0] idx);
    coef_e c;
    case (idx)
      ENTRY_AA:                               c = COEF_A;
      ENTRY_AB, ENTRY_BB:                     c = COEF_B;
      ENTRY_AC, ENTRY_BC, ENTRY_CC:           c = COEF_C;
      ENTRY_AD, ENTRY_BD, ENTRY_CD, ENTRY_DD: c = COEF_D;
      default:                                c = COEF_A;
    endcase
    return c;
  endfunction

endpackage

// ===== design/tpqg_fifo.sv =====
// Small register queue used between the plane and entry pipelines and at the result side.
module tpqg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTRW-1:0]  wr_q, wr_d;
  logic [PTRW-1:0]  rd_q, rd_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;

  always_comb begin
    wr_d = (wr_q == PTRW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    rd_d = (rd_q == PTRW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_d;
      end
      if (pop_i) begin
        rd_q <= rd_d;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_q];
  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign empty_o = (cnt_q == '0);

endmodule

// ===== design/tpqg_front.sv =====
// Plane pipeline: accepts triangles and forms the plane coefficients A, B, C and D.
module tpqg_front #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  tpqg_pkg::tri_in_t              in_data_i,
  output logic                           in_stall_o,
  output logic                           plane_push_o,
  output logic [4*(3*COORD_WIDTH+5)-1:0] plane_o,
  input  logic                           plane_full_i
);

  localparam int CW  = COORD_WIDTH;
  localparam int DFW = CW + 1;
  localparam int XW  = 2 * CW + 2;
  localparam int AW  = 2 * CW + 3;
  localparam int HW  = (AW + 1) / 2;
  localparam int GW  = AW - HW;
  localparam int PHW = GW + CW;
  localparam int PLW = HW + 1 + CW;
  localparam int TW  = AW + CW;
  localparam int DW  = 3 * CW + 5;

  function automatic logic signed [CW-1:0] crd(
    input logic signed [tpqg_pkg::COORD_IN_W-1:0] v
  );
    return CW'($unsigned(v));
  endfunction

  logic       en;
  logic [5:0] vld_q;

  logic signed [CW-1:0]  x1_q, y1_q, z1_q;
  logic signed [DFW-1:0] ux_q, uy_q, uz_q, vx_q, vy_q, vz_q;
  logic signed [CW-1:0]  x2_q, y2_q, z2_q;
  logic signed [XW-1:0]  m0_q, m1_q, m2_q, m3_q, m4_q, m5_q;
  logic signed [CW-1:0]  x3_q, y3_q, z3_q;
  logic signed [AW-1:0]  a3_q, b3_q, c3_q;
  logic signed [AW-1:0]  a4_q, b4_q, c4_q;
  logic signed [PHW-1:0] ah_q, bh_q, ch_q;
  logic signed [PLW-1:0] al_q, bl_q, cl_q;
  logic signed [AW-1:0]  a5_q, b5_q, c5_q;
  logic signed [TW-1:0]  ta_q, tb_q, tc_q;
  logic signed [DW-1:0]  a6_q, b6_q, c6_q, d6_q;

  assign en           = !vld_q[5] || !plane_full_i;
  assign in_stall_o   = !en;
  assign plane_push_o = vld_q[5] && !plane_full_i;
  assign plane_o      = {d6_q, c6_q, b6_q, a6_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[4:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q <= crd(in_data_i.first_x);
      y1_q <= crd(in_data_i.first_y);
      z1_q <= crd(in_data_i.first_z);
      ux_q <= DFW'(crd(in_data_i.second_x)) - DFW'(crd(in_data_i.first_x));
      uy_q <= DFW'(crd(in_data_i.second_y)) - DFW'(crd(in_data_i.first_y));
      uz_q <= DFW'(crd(in_data_i.second_z)) - DFW'(crd(in_data_i.first_z));
      vx_q <= DFW'(crd(in_data_i.third_x)) - DFW'(crd(in_data_i.first_x));
      vy_q <= DFW'(crd(in_data_i.third_y)) - DFW'(crd(in_data_i.first_y));
      vz_q <= DFW'(crd(in_data_i.third_z)) - DFW'(crd(in_data_i.first_z));

      x2_q <= x1_q;
      y2_q <= y1_q;
      z2_q <= z1_q;
      m0_q <= XW'(uy_q) * XW'(vz_q);
      m1_q <= XW'(vy_q) * XW'(uz_q);
      m2_q <= XW'(vx_q) * XW'(uz_q);
      m3_q <= XW'(ux_q) * XW'(vz_q);
      m4_q <= XW'(ux_q) * XW'(vy_q);
      m5_q <= XW'(uy_q) * XW'(vx_q);

      x3_q <= x2_q;
      y3_q <= y2_q;
      z3_q <= z2_q;
      a3_q <= AW'(m0_q) - AW'(m1_q);
      b3_q <= AW'(m2_q) - AW'(m3_q);
      c3_q <= AW'(m4_q) - AW'(m5_q);

      a4_q <= a3_q;
      b4_q <= b3_q;
      c4_q <= c3_q;
      ah_q <= PHW'($signed(a3_q[AW-1:HW])) * PHW'(x3_q);
      bh_q <= PHW'($signed(b3_q[AW-1:HW])) * PHW'(y3_q);
      ch_q <= PHW'($signed(c3_q[AW-1:HW])) * PHW'(z3_q);
      al_q <= PLW'($signed({1'b0, a3_q[HW-1:0]})) * PLW'(x3_q);
      bl_q <= PLW'($signed({1'b0, b3_q[HW-1:0]})) * PLW'(y3_q);
      cl_q <= PLW'($signed({1'b0, c3_q[HW-1:0]})) * PLW'(z3_q);

      a5_q <= a4_q;
      b5_q <= b4_q;
      c5_q <= c4_q;
      ta_q <= (TW'(ah_q) <<< HW) + TW'(al_q);
      tb_q <= (TW'(bh_q) <<< HW) + TW'(bl_q);
      tc_q <= (TW'(ch_q) <<< HW) + TW'(cl_q);

      a6_q <= DW'(a5_q);
      b6_q <= DW'(b5_q);
      c6_q <= DW'(c5_q);
      d6_q <= -(DW'(ta_q) + DW'(tb_q) + DW'(tc_q));
    end
  end

endmodule

// ===== design/tpqg_back.sv =====
// Entry pipeline: steps through the ten quadric entries of each plane, then shifts and saturates.
module tpqg_back #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           plane_valid_i,
  input  logic [4*(3*COORD_WIDTH+5)-1:0] plane_i,
  output logic                           plane_pop_o,
  input  logic [tpqg_pkg::SHIFT_W-1:0]   shift_i,
  output logic                           out_push_o,
  output tpqg_pkg::entry_t               out_data_o,
  input  logic                           out_full_i
);

  localparam int DW  = 3 * COORD_WIDTH + 5;
  localparam int NL  = 3;
  localparam int LW  = (DW + NL - 1) / NL;
  localparam int EW  = NL * LW;
  localparam int PPW = 2 * (LW + 1);
  localparam int PW  = 2 * EW;
  localparam int SW  = (PW > tpqg_pkg::VALUE_W) ? PW : tpqg_pkg::VALUE_W + 1;

  logic en;
  logic issue;
  logic [5:0] vld_q;
  logic [3:0] k_q, k_d;
  tpqg_pkg::coef_e row_s, col_s;

  logic [4:0][3:0] idx_q;
  logic [4:0]      last_q;

  logic signed [DW-1:0]  opa_q, opb_q;
  logic signed [EW-1:0]  ae, be;
  logic signed [LW:0]    la [NL];
  logic signed [LW:0]    lb [NL];
  logic signed [PPW-1:0] pp_d [NL][NL];
  logic signed [PPW-1:0] pp_q [NL][NL];
  logic signed [PW-1:0]  rs_d [NL];
  logic signed [PW-1:0]  rs_q [NL];
  logic signed [PW-1:0]  tot_d, tot_q;
  logic signed [SW-1:0]  sh_q;
  logic [SW-64:0]        top_s;
  logic                  sat_s;
  tpqg_pkg::entry_t      entry_d, entry_q;

  assign en          = !vld_q[5] || !out_full_i;
  assign issue       = en && plane_valid_i;
  assign plane_pop_o = issue && (k_q == tpqg_pkg::ENTRY_DD);
  assign out_push_o  = vld_q[5] && !out_full_i;
  assign out_data_o  = entry_q;

  assign row_s = tpqg_pkg::entry_row(k_q);
  assign col_s = tpqg_pkg::entry_col(k_q);
  assign k_d   = (k_q == tpqg_pkg::ENTRY_DD) ? tpqg_pkg::ENTRY_AA : k_q + 4'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      k_q   <= tpqg_pkg::ENTRY_AA;
    end else begin
      if (en) begin
        vld_q <= {vld_q[4:0], plane_valid_i};
      end
      if (issue) begin
        k_q <= k_d;
      end
    end
  end

  always_comb begin
    ae = EW'(opa_q);
    be = EW'(opb_q);
    for (int i = 0; i < NL; i++) begin
      la[i] = $signed({(i == NL - 1) ? ae[EW-1] : 1'b0, ae[i*LW +: LW]});
      lb[i] = $signed({(i == NL - 1) ? be[EW-1] : 1'b0, be[i*LW +: LW]});
    end
    for (int i = 0; i < NL; i++) begin
      for (int j = 0; j < NL; j++) begin
        pp_d[i][j] = PPW'(la[i]) * PPW'(lb[j]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      rs_d[i] = '0;
      for (int j = 0; j < NL; j++) begin
        rs_d[i] = rs_d[i] + (PW'(pp_q[i][j]) <<< (j * LW));
      end
    end
    tot_d = '0;
    for (int i = 0; i < NL; i++) begin
      tot_d = tot_d + (rs_q[i] <<< (i * LW));
    end
  end

  always_comb begin
    top_s = sh_q[SW-1:63];
    sat_s = (top_s != '0) && (top_s != '1);
    entry_d.entry_index = idx_q[4];
    entry_d.saturated   = sat_s;
    entry_d.last_entry  = last_q[4];
    if (sat_s) begin
      entry_d.entry_value = sh_q[SW-1] ? tpqg_pkg::SAT_MIN : tpqg_pkg::SAT_MAX;
    end else begin
      entry_d.entry_value = sh_q[63:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      opa_q   <= plane_i[row_s*DW +: DW];
      opb_q   <= plane_i[col_s*DW +: DW];
      idx_q   <= {idx_q[3:0], k_q};
      last_q  <= {last_q[3:0], k_q == tpqg_pkg::ENTRY_DD};
      pp_q    <= pp_d;
      rs_q    <= rs_d;
      tot_q   <= tot_d;
      sh_q    <= SW'(tot_q) >>> shift_i;
      entry_q <= entry_d;
    end
  end

endmodule

// ===== design/triangle_plane_quadric_generator.sv =====
// Top level of the triangle plane quadric generator: plane pipeline, plane queue, entry pipeline.
//
//   Channel   Direction  Handshake                     Word
//   input     in         push, full                    in_data_i (three vertices)
//   result    out        empty, pop                    out_data_o (one quadric entry)
//   config    in         cfg_valid_i, cfg_ready_o      cfg_data_i (product shift)
//
// Each triangle gives ten result words, one per cycle from the entry pipeline while the
// result queue has room, so in steady state the entry pipeline and the result port set how
// often a new triangle is taken. Reset clears the queues, the pipeline valid bits and the
// product shift; there is no clearing pass. With pop low the result queue fills, the entry
// pipeline holds, the plane queue fills, and full rises once the plane pipeline's last stage
// cannot move on.
module triangle_plane_quadric_generator #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  tpqg_pkg::tri_in_t            in_data_i,
  output logic                         empty,
  input  logic                         pop,
  output tpqg_pkg::entry_t             out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tpqg_pkg::SHIFT_W-1:0] cfg_data_i
);

  localparam int DW  = 3 * COORD_WIDTH + 5;
  localparam int PLW = 4 * DW;
  localparam int EW  = $bits(tpqg_pkg::entry_t);

  logic [tpqg_pkg::SHIFT_W-1:0] shift_q;
  logic                         in_stall;
  logic                         plane_push, plane_pop, plane_full, plane_empty;
  logic [PLW-1:0]               plane_in, plane_head;
  logic                         res_push, res_full;
  tpqg_pkg::entry_t             res_in;
  logic [EW-1:0]                res_head;

  assign cfg_ready_o = 1'b1;
  assign full        = in_stall;
  assign out_data_o  = tpqg_pkg::entry_t'(res_head);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
    end else if (cfg_valid_i) begin
      shift_q <= cfg_data_i;
    end
  end

  tpqg_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (push),
    .in_data_i    (in_data_i),
    .in_stall_o   (in_stall),
    .plane_push_o (plane_push),
    .plane_o      (plane_in),
    .plane_full_i (plane_full)
  );

  tpqg_fifo #(
    .WIDTH(PLW),
    .DEPTH(2)
  ) u_plane_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (plane_push),
    .data_i  (plane_in),
    .pop_i   (plane_pop),
    .data_o  (plane_head),
    .full_o  (plane_full),
    .empty_o (plane_empty)
  );

  tpqg_back #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .plane_valid_i (!plane_empty),
    .plane_i       (plane_head),
    .plane_pop_o   (plane_pop),
    .shift_i       (shift_q),
    .out_push_o    (res_push),
    .out_data_o    (res_in),
    .out_full_i    (res_full)
  );

  tpqg_fifo #(
    .WIDTH(EW),
    .DEPTH(2)
  ) u_result_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .pop_i   (pop && !empty),
    .data_o  (res_head),
    .full_o  (res_full),
    .empty_o (empty)
  );

  a_entry_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !empty && !out_data_o.last_entry |=>
      empty || (out_data_o.entry_index == 4'($past(out_data_o.entry_index) + 4'd1)))
    else $error("result entries out of order within a triangle");

  a_entry_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !empty && out_data_o.last_entry |=>
      empty || (out_data_o.entry_index == tpqg_pkg::ENTRY_AA))
    else $error("triangle does not restart at the first entry");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_data_o.saturated |->
      (out_data_o.entry_value == tpqg_pkg::SAT_MAX) ||
      (out_data_o.entry_value == tpqg_pkg::SAT_MIN))
    else $error("saturated entry is not at a range limit");

  a_square_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && ((out_data_o.entry_index == tpqg_pkg::ENTRY_AA) ||
               (out_data_o.entry_index == tpqg_pkg::ENTRY_BB) ||
               (out_data_o.entry_index == tpqg_pkg::ENTRY_CC) ||
               (out_data_o.entry_index == tpqg_pkg::ENTRY_DD)) |->
      !out_data_o.entry_value[63])
    else $error("diagonal quadric entry is negative");

endmodule
